// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the text window line writer.
// Standalone header, no dependencies; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TWLW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TWLW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/twlw_pkg.sv =====
// Package for the text window line writer: sizes, character codes,
// result kinds and the beat, state and control structs. No dependencies.
`timescale 1ns / 1ps

package twlw_pkg;

  localparam int WINDOWS = 16;
  localparam int COLUMNS = 32;
  localparam int ROWS    = 24;

  localparam int WIN_AW = $clog2(WINDOWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int CNT_W  = COL_W + 1;
  localparam int ROW_W  = $clog2(ROWS + 1);

  localparam logic [7:0] CHR_TAB   = 8'd9;
  localparam logic [7:0] CHR_NL    = 8'd10;
  localparam logic [7:0] CHR_SPACE = 8'd32;
  localparam logic [7:0] CHR_PCT   = 8'd37;
  localparam logic [7:0] CHR_ZERO  = 8'd48;
  localparam logic [7:0] CHR_THREE = 8'd51;

  localparam logic [1:0] KIND_CELL   = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_COMMIT = 2'd2;

  typedef struct packed {
    logic [3:0] window;
    logic [7:0] char_code;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  target_window;
    logic [4:0]  column;
    logic [15:0] tile;
    logic [4:0]  row;
    logic [5:0]  count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       colour;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             pending;
  } win_state_t;

  typedef struct packed {
    logic busy;
    logic finish;
    logic emit;
  } seq_ctrl_t;

endpackage

// ===== rtl/text_window_line_writer.sv =====
// Text window line writer top level: input stage, window state memory,
// sequencer and output register. Depends on twlw_pkg, twlw_seq and assert_macros.svh.
//
// Usage: one character beat per window on in_data (window, char_code,
// message_end); each beat yields zero to seven result beats on out_data
// (cell write, scroll, commit line), the final one flagged by last.
// Both channels: a beat moves on a rising edge with valid high, stall low.
// The first result of an accepted beat passes the input stage, the
// sequencer and the output register. Throughput: one result beat per
// cycle while out_stall is low; the next character loads in the cycle
// the sequencer finishes, also after one that yields no result (percent
// held, colour escape). Beats for the same window follow back to back;
// the next state is forwarded from the sequencer or from the write-back
// into the memory.
// Reset: all windows read as colour 0, row 0, column 0, nothing pending,
// from per-entry valid bits; no clearing pass. in_stall is high during
// reset. A stalled output holds its beat; the sequencer pauses and the
// input stage fills, then in_stall rises.
`timescale 1ns / 1ps

module text_window_line_writer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  twlw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output twlw_pkg::out_item_t out_data
);

`include "assert_macros.svh"

  logic run_r;
  logic stg_valid_r;
  twlw_pkg::in_item_t stg_item_r;

  twlw_pkg::win_state_t mem_r [twlw_pkg::WINDOWS];
  logic [twlw_pkg::WINDOWS-1:0] ent_valid_r;
  twlw_pkg::win_state_t rd_data_r, wb_data_r, ld_state;
  logic rd_valid_r, wb_hit_r;
  logic [twlw_pkg::WIN_AW-1:0] rd_addr, wr_addr;

  twlw_pkg::seq_ctrl_t  seq_ctrl;
  twlw_pkg::win_state_t wb_state;
  logic [3:0]           wb_window;
  twlw_pkg::out_item_t  seq_res;

  logic in_accept, load, slot_free;
  logic out_valid_r;
  twlw_pkg::out_item_t out_data_r;

  assign load      = stg_valid_r && (!seq_ctrl.busy || seq_ctrl.finish);
  assign in_stall  = !run_r || (stg_valid_r && !load);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign rd_addr = in_accept ? in_data.window[twlw_pkg::WIN_AW-1:0]
                             : stg_item_r.window[twlw_pkg::WIN_AW-1:0];
  assign wr_addr = wb_window[twlw_pkg::WIN_AW-1:0];

  always_comb begin
    if (seq_ctrl.finish && wb_window == stg_item_r.window) begin
      ld_state = wb_state;
    end else if (wb_hit_r) begin
      ld_state = wb_data_r;
    end else if (rd_valid_r) begin
      ld_state = rd_data_r;
    end else begin
      ld_state = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      stg_valid_r <= 1'b0;
      ent_valid_r <= '0;
      wb_hit_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      run_r <= 1'b1;
      if (in_accept) begin
        stg_valid_r <= 1'b1;
      end else if (load) begin
        stg_valid_r <= 1'b0;
      end
      if (seq_ctrl.finish) begin
        ent_valid_r[wr_addr] <= 1'b1;
      end
      wb_hit_r <= seq_ctrl.finish && (wr_addr == rd_addr);
      if (seq_ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Window state memory, registered read
  always_ff @(posedge clk) begin
    if (seq_ctrl.finish) begin
      mem_r[wr_addr] <= wb_state;
    end
    rd_data_r  <= mem_r[rd_addr];
    rd_valid_r <= ent_valid_r[rd_addr];
    wb_data_r  <= wb_state;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stg_item_r <= in_data;
    end
    if (seq_ctrl.emit) begin
      out_data_r <= seq_res;
    end
  end

  twlw_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_item  (stg_item_r),
    .load_state (ld_state),
    .slot_free  (slot_free),
    .ctrl       (seq_ctrl),
    .wb_state   (wb_state),
    .wb_window  (wb_window),
    .res        (seq_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TWLW_ASSERT_NOW(a_emit_slot, seq_ctrl.emit, slot_free, "result issued into a full slot")
  `TWLW_ASSERT_NEXT(a_stage_hold, stg_valid_r && !load, stg_valid_r && $stable(stg_item_r), "stage lost its beat")
  `TWLW_ASSERT_NOW(a_wb_row, seq_ctrl.finish, wb_state.row <= twlw_pkg::ROW_W'(twlw_pkg::ROWS), "row beyond limit")

endmodule

// ===== rtl/twlw_seq.sv =====
// Per-character sequencer: holds one window's working state and issues
// one result beat per step. Depends on twlw_pkg.
`timescale 1ns / 1ps

module twlw_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  twlw_pkg::in_item_t  load_item,
  input  twlw_pkg::win_state_t load_state,
  input  logic                slot_free,
  output twlw_pkg::seq_ctrl_t ctrl,
  output twlw_pkg::win_state_t wb_state,
  output logic [3:0]          wb_window,
  output twlw_pkg::out_item_t res
);

  logic busy_r, pct_r, chr_todo_r, commit_r;
  logic [1:0] colour_r;
  logic [twlw_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [twlw_pkg::CNT_W-1:0] col_r, col_nxt;
  logic pending_r;
  logic [7:0] chr_r;
  logic [3:0] win_r;

  logic pct_nxt, chr_todo_nxt, commit_nxt;
  logic is_tab, is_nl, no_work, commit_now;
  logic [7:0] cell_chr;
  logic [15:0] tile_base;

  logic ld_digit, ld_hold;

  assign is_tab     = (chr_r == twlw_pkg::CHR_TAB);
  assign is_nl      = (chr_r == twlw_pkg::CHR_NL);
  assign no_work    = !(commit_r || pct_r || chr_todo_r);
  assign commit_now = commit_r || (!pct_r && chr_todo_r && is_nl);
  assign tile_base  = 16'({colour_r, 7'd0});

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    pct_nxt      = pct_r;
    chr_todo_nxt = chr_todo_r;
    commit_nxt   = commit_r;
    cell_chr     = twlw_pkg::CHR_PCT;
    res          = '0;
    res.target_window = win_r;
    if (commit_now) begin
      if (!commit_r) begin
        chr_todo_nxt = 1'b0;
      end
      if (row_r >= twlw_pkg::ROW_W'(twlw_pkg::ROWS)) begin
        res.kind   = twlw_pkg::KIND_SCROLL;
        row_nxt    = twlw_pkg::ROW_W'(twlw_pkg::ROWS - 1);
        commit_nxt = 1'b1;
      end else begin
        res.kind   = twlw_pkg::KIND_COMMIT;
        res.row    = 5'(row_r);
        res.count  = 6'(col_r);
        col_nxt    = '0;
        row_nxt    = row_r + 1'b1;
        commit_nxt = 1'b0;
      end
    end else if (pct_r || chr_todo_r) begin
      if (!pct_r) begin
        cell_chr = is_tab ? twlw_pkg::CHR_SPACE : chr_r;
      end
      res.kind   = twlw_pkg::KIND_CELL;
      res.column = 5'(col_r);
      res.tile   = 16'(cell_chr) - 16'(twlw_pkg::CHR_SPACE) + tile_base;
      col_nxt    = col_r + 1'b1;
      commit_nxt = (col_nxt == twlw_pkg::CNT_W'(twlw_pkg::COLUMNS));
      if (pct_r) begin
        pct_nxt = 1'b0;
      end else if (!is_tab || col_nxt[1:0] == 2'b00 || commit_nxt) begin
        chr_todo_nxt = 1'b0;
      end
    end
    res.last = !(commit_nxt || pct_nxt || chr_todo_nxt);
  end

  assign ctrl.busy   = busy_r;
  assign ctrl.emit   = busy_r && slot_free && !no_work;
  assign ctrl.finish = busy_r && (no_work || (slot_free && res.last));

  assign wb_window = win_r;
  assign wb_state  = '{colour: colour_r, row: row_nxt,
                       column: col_nxt[twlw_pkg::COL_W-1:0], pending: pending_r};

  // Colour escape, percent hold and literal percent decided on load
  assign ld_digit = load_state.pending && (load_item.char_code >= twlw_pkg::CHR_ZERO)
                    && (load_item.char_code <= twlw_pkg::CHR_THREE);
  assign ld_hold  = (load_item.char_code == twlw_pkg::CHR_PCT) && !load_item.message_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      pct_r      <= 1'b0;
      chr_todo_r <= 1'b0;
      commit_r   <= 1'b0;
    end else if (load) begin
      busy_r     <= 1'b1;
      pct_r      <= load_state.pending && !ld_digit;
      chr_todo_r <= !ld_digit && !ld_hold;
      commit_r   <= 1'b0;
    end else begin
      if (ctrl.finish) begin
        busy_r <= 1'b0;
      end
      if (ctrl.emit) begin
        pct_r      <= pct_nxt;
        chr_todo_r <= chr_todo_nxt;
        commit_r   <= commit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      colour_r  <= ld_digit ? load_item.char_code[1:0] : load_state.colour;
      row_r     <= load_state.row;
      col_r     <= {1'b0, load_state.column};
      pending_r <= !ld_digit && ld_hold;
      chr_r     <= load_item.char_code;
      win_r     <= load_item.window;
    end else if (ctrl.emit) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// ===== tb/sv/twlw_checker.sv =====
// Checker for the text window line writer: watches both channels, predicts the
// result beats of each accepted character and compares them in order.
// Depends on twlw_pkg for the beat structs, sizes, character codes and kinds.
`timescale 1ns / 1ps

module twlw_checker
  import twlw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        results_due,
  output int        fail_count
);

  logic [1:0]  win_colour [WINDOWS];
  int unsigned win_row    [WINDOWS];
  int unsigned win_col    [WINDOWS];
  bit          win_pct    [WINDOWS];

  out_item_t due_q[$];
  out_item_t char_beats[$];
  int        mismatches = 0;

  assign fail_count = mismatches;

  task automatic report(input string msg);
    if (mismatches < 50) begin
      $display("twlw_checker: %s at %0t", msg, $realtime);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report($sformatf("%s mismatch: got %0h, want %0h", name, got, want));
    end
  endtask

  function automatic void add_action(logic [1:0] kind, logic [3:0] w, int unsigned col,
                                     int unsigned tile, int unsigned row,
                                     int unsigned cnt);
    out_item_t b;
    if (char_beats.size() >= 8) return;
    b.kind          = kind;
    b.target_window = w;
    b.column        = col[4:0];
    b.tile          = tile[15:0];
    b.row           = row[4:0];
    b.count         = cnt[5:0];
    b.last          = 1'b0;
    char_beats.push_back(b);
  endfunction

  function automatic void close_line(logic [3:0] w);
    if (win_row[w] >= ROWS) begin
      add_action(KIND_SCROLL, w, 0, 0, 0, 0);
      win_row[w] = ROWS - 1;
    end
    add_action(KIND_COMMIT, w, 0, 0, win_row[w], win_col[w]);
    win_col[w] = 0;
    win_row[w]++;
  endfunction

  function automatic void write_cell(logic [3:0] w, logic [7:0] c);
    logic [15:0] t;
    t = 16'(c) - 16'd32 + 16'(win_colour[w]) * 16'd128;
    add_action(KIND_CELL, w, win_col[w], t, 0, 0);
    win_col[w]++;
  endfunction

  function automatic void handle_char(logic [3:0] w, logic [7:0] c);
    int unsigned pad;
    if (c == CHR_TAB) begin
      pad = 4 - (win_col[w] % 4);
      for (int i = 0; i < pad && win_col[w] < COLUMNS; i++) write_cell(w, CHR_SPACE);
      if (win_col[w] >= COLUMNS) close_line(w);
    end else if (c == CHR_NL) begin
      close_line(w);
    end else begin
      if (win_col[w] < COLUMNS) write_cell(w, c);
      if (win_col[w] >= COLUMNS) close_line(w);
    end
  endfunction

  function automatic void predict_char(in_item_t it);
    logic [3:0] w;
    logic [7:0] c;
    out_item_t  b;
    w = it.window;
    c = it.char_code;
    char_beats.delete();
    if (win_pct[w]) begin
      win_pct[w] = 1'b0;
      if (c >= CHR_ZERO && c <= CHR_THREE) begin
        win_colour[w] = 2'(c - CHR_ZERO);
        return;
      end
      handle_char(w, CHR_PCT);
    end
    if (c == CHR_PCT && !it.message_end) win_pct[w] = 1'b1;
    else handle_char(w, c);
    if (char_beats.size() > 0) begin
      b = char_beats.pop_back();
      b.last = 1'b1;
      char_beats.push_back(b);
    end
    foreach (char_beats[i]) due_q.push_back(char_beats[i]);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < WINDOWS; i++) begin
        win_colour[i] = '0;
        win_row[i]    = 0;
        win_col[i]    = 0;
        win_pct[i]    = 1'b0;
      end
      due_q.delete();
    end else begin
      if (in_valid && !in_stall) predict_char(in_data);
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          report($sformatf("result beat %h with nothing expected", out_data));
        end else begin
          want = due_q.pop_front();
          check_field("kind", out_data.kind, want.kind);
          check_field("target_window", out_data.target_window, want.target_window);
          check_field("column", out_data.column, want.column);
          check_field("tile", out_data.tile, want.tile);
          check_field("row", out_data.row, want.row);
          check_field("count", out_data.count, want.count);
          check_field("last", out_data.last, want.last);
        end
      end
    end
    results_due <= due_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the text window line writer: clock, reset, character
// stimulus and result-side stall. Depends on twlw_pkg, twlw_checker and the block.
`timescale 1ns / 1ps

module tb_top;
  import twlw_pkg::*;

  localparam int ITEMS_RANDOM = 280;
  localparam int HOLD_CYCLES  = 300;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int results_due;
  int fail_count;
  int sent;
  int base;
  bit idle_on;
  bit hold_req;
  bit drained;

  text_window_line_writer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  twlw_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .results_due (results_due),
    .fail_count  (fail_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic send_char(input logic [3:0] w, input logic [7:0] c, input logic e);
    in_item_t it;
    it.window      = w;
    it.char_code   = c;
    it.message_end = e;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return 8'($urandom_range(32, 126));
    if (r < 10) return CHR_TAB;
    if (r < 13) return CHR_NL;
    if (r < 16) return CHR_PCT;
    if (r < 18) return 8'($urandom_range(CHR_ZERO, CHR_THREE));
    return 8'($urandom);
  endfunction

  task automatic send_message();
    logic [3:0] w;
    logic [7:0] c;
    int         len;
    int         pick;
    bit         prev_pct;
    prev_pct = 1'b0;
    w = ($urandom_range(0, 4) < 2) ? 4'($urandom_range(0, 1)) : 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      // run of newlines, drives rows into scrolling
      len = $urandom_range(8, 20);
      for (int i = 0; i < len; i++) send_char(w, CHR_NL, i == len - 1);
    end else if (pick < 4) begin
      len = $urandom_range(28, 36);
      for (int i = 0; i < len; i++) send_char(w, 8'($urandom_range(32, 126)), i == len - 1);
    end else if (pick < 6) begin
      send_char(4'($urandom), 8'($urandom), 1'($urandom));
    end else begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        c = (prev_pct && $urandom_range(0, 1)) ? 8'($urandom_range(CHR_ZERO, CHR_THREE))
                                                : pick_char();
        send_char(w, c, i == len - 1);
        prev_pct = (c == CHR_PCT);
      end
    end
  endtask

  // result side: random stall bursts, plus one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    sent     = 0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    drained  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_char(4'h0, 8'h41, 1'b0);
    send_char(4'h0, 8'h00, 1'b0);
    send_char(4'h0, 8'hFF, 1'b0);
    send_char(4'h0, CHR_TAB, 1'b0);
    send_char(4'h0, CHR_TAB, 1'b0);
    send_char(4'h0, CHR_PCT, 1'b0);
    send_char(4'h0, CHR_THREE, 1'b0);
    send_char(4'h0, 8'h7A, 1'b0);
    send_char(4'h0, CHR_PCT, 1'b0);
    send_char(4'h0, CHR_PCT, 1'b0);
    send_char(4'h0, CHR_ZERO, 1'b0);
    send_char(4'h0, CHR_PCT, 1'b0);
    send_char(4'h0, 8'h71, 1'b1);
    send_char(4'h0, CHR_PCT, 1'b1);
    send_char(4'h0, CHR_NL, 1'b0);
    send_char(4'hF, 8'h1F, 1'b1);
    send_char(4'hF, CHR_PCT, 1'b0);
    send_char(4'hF, CHR_NL, 1'b1);
    send_char(4'hF, CHR_NL, 1'b0);
    send_char(4'hF, CHR_PCT, 1'b0);
    send_char(4'hF, CHR_ZERO + 8'd1, 1'b0);
    // eight tabs fill a whole line and commit it
    for (int i = 0; i < 8; i++) send_char(4'hF, CHR_TAB, i == 7);

    base = sent;
    while (sent < base + ITEMS_RANDOM) begin
      idle_on = !((sent >= base + 150 && sent < base + 190) || sent >= base + 240);
      if (sent >= base + 100) hold_req = 1'b1;
      if (!drained && sent >= base + 200) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
      end
      send_message();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== text_window_line_writer.f =====
+incdir+rtl
rtl/twlw_pkg.sv
rtl/twlw_seq.sv
rtl/text_window_line_writer.sv
tb/sv/twlw_checker.sv
tb/sv/tb_top.sv
